// ===== rtl/sbd_pkg.sv =====
// Shared constants, types and helpers for the sound CPU bus decoder.
`timescale 1ns / 1ps

package sbd_pkg;

    // Local RAM geometry (fills the low 8 KiB of the CPU space)
    localparam int RAM_DEPTH = 8192;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);
    localparam int RAM_FOLDS = (8192 - 1) / RAM_DEPTH;

    // Bank register width; window address is {bank, offset[14:1]}
    localparam int BANK_BITS = 9;

    localparam logic [15:0] RAM_END      = 16'h2000;
    localparam logic [15:0] SOUND_FIRST  = 16'h4000;
    localparam logic [15:0] SOUND_LAST   = 16'h4003;
    localparam logic [15:0] BANK_ADDR_0  = 16'h6000;
    localparam logic [15:0] BANK_ADDR_1  = 16'h6001;
    localparam logic [15:0] TONE_ADDR    = 16'h7F11;
    localparam logic [15:0] WINDOW_FIRST = 16'h8000;

    localparam logic [22:0] TONE_WORD_ADDR = 23'(24'hC00010 >> 1);

    typedef enum logic [2:0] {
        TGT_RAM      = 3'd0,
        TGT_SOUND    = 3'd1,
        TGT_BANK     = 3'd2,
        TGT_TONE     = 3'd3,
        TGT_WINDOW   = 3'd4,
        TGT_UNMAPPED = 3'd5
    } target_t;

    typedef struct packed {
        logic              en;
        logic              we;
        logic [RAM_AW-1:0] idx;
        logic [7:0]        wdata;
    } lram_req_t;

    // Address modulo RAM_DEPTH by repeated compare-subtract (RAM_FOLDS steps)
    function automatic logic [RAM_AW-1:0] ram_index(input logic [12:0] a);
        logic [13:0] v;
        v = {1'b0, a};
        for (int i = 0; i < RAM_FOLDS; i++)
        begin
            if (v >= 14'(RAM_DEPTH))
            begin
                v = v - 14'(RAM_DEPTH);
            end
        end
        return v[RAM_AW-1:0];
    endfunction

endpackage

// ===== rtl/sound_cpu_bus_decoder_banked.sv =====
// Top level: banked memory window bus decoder for the sound CPU.
`timescale 1ns / 1ps

// Channel  Dir  Width            Contents
// s_*      in   tdata 24, tuser 1  one CPU bus access (address, write byte, mode)
// m_*      out  tdata 56, tuser 3  decode result (target and per-target fields)
//
// Throughput is one transfer per cycle unless m_tready stalls; an input
// transfer reaches m_tvalid through the decode stage and the output register,
// matching the registered read of the local RAM. After reset the RAM is swept
// to zero, one byte per cycle: s_tready stays low until the sweep is done.
// A stall on m_tready holds the decode stage; s_tready then drops.

module sound_cpu_bus_decoder_banked (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_tuser,   // [0] mode (1 = write)

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] read_data, [8] sound_port,
                                   // [9] sound_is_data, [32:10] main_word_address,
                                   // [33] upper_strobe, [34] lower_strobe,
                                   // [50:35] main_write_word, [51] main_request,
                                   // [55:52] zero
    output logic [2:0]  m_tuser    // [2:0] target
);

    // Input fields
    logic        in_wr;
    logic [15:0] in_addr;
    logic [7:0]  in_data;

    assign in_wr   = s_tuser;
    assign in_addr = s_tdata[15:0];
    assign in_data = s_tdata[23:16];

    logic s_xfer;
    logic adv;
    logic ram_busy;

    // Bank register
    logic [sbd_pkg::BANK_BITS-1:0] bank_reg;
    logic [sbd_pkg::BANK_BITS-1:0] bank_next;

    // Decode results (combinational, from the accepted access)
    sbd_pkg::target_t d_tgt;
    logic             d_port;
    logic             d_isdata;
    logic [22:0]      d_waddr;
    logic             d_ustb;
    logic             d_lstb;
    logic [15:0]      d_wword;
    logic             d_req;

    // Decode stage (RAM read in flight)
    logic             v1_reg;
    sbd_pkg::target_t tgt1_reg;
    logic             wr1_reg;
    logic             port1_reg;
    logic             isdata1_reg;
    logic [22:0]      waddr1_reg;
    logic             ustb1_reg;
    logic             lstb1_reg;
    logic [15:0]      wword1_reg;
    logic             req1_reg;

    // Output register
    logic             ov_reg;
    sbd_pkg::target_t otgt_reg;
    logic [7:0]       ord_reg;
    logic             oport_reg;
    logic             oisdata_reg;
    logic [22:0]      owaddr_reg;
    logic             oustb_reg;
    logic             olstb_reg;
    logic [15:0]      owword_reg;
    logic             oreq_reg;

    sbd_pkg::lram_req_t ram_req;
    logic [7:0]         ram_rdata;

    assign adv      = !ov_reg || m_tready;
    assign s_tready = !ram_busy && (!v1_reg || adv);
    assign s_xfer   = s_tvalid && s_tready;

    // Address decode
    always_comb
    begin
        d_tgt     = sbd_pkg::TGT_UNMAPPED;
        d_port    = 1'b0;
        d_isdata  = 1'b0;
        d_waddr   = '0;
        d_ustb    = 1'b0;
        d_lstb    = 1'b0;
        d_wword   = '0;
        d_req     = 1'b0;
        bank_next = bank_reg;
        if (in_addr < sbd_pkg::RAM_END)
        begin
            d_tgt = sbd_pkg::TGT_RAM;
        end
        else if (in_addr >= sbd_pkg::SOUND_FIRST && in_addr <= sbd_pkg::SOUND_LAST)
        begin
            d_tgt    = sbd_pkg::TGT_SOUND;
            d_port   = in_addr[1];
            d_isdata = in_addr[0];
        end
        else if (in_addr == sbd_pkg::BANK_ADDR_0 || in_addr == sbd_pkg::BANK_ADDR_1)
        begin
            d_tgt = sbd_pkg::TGT_BANK;
            if (in_wr)
            begin
                // shift in from the top
                bank_next = (bank_reg >> 1)
                          | (sbd_pkg::BANK_BITS'(in_data[0]) << (sbd_pkg::BANK_BITS - 1));
            end
        end
        else if (in_addr == sbd_pkg::TONE_ADDR)
        begin
            d_tgt = sbd_pkg::TGT_TONE;
            if (in_wr)
            begin
                d_waddr = sbd_pkg::TONE_WORD_ADDR;
                d_lstb  = 1'b1;
                d_wword = {8'h00, in_data};
                d_req   = 1'b1;
            end
        end
        else if (in_addr >= sbd_pkg::WINDOW_FIRST)
        begin
            d_tgt   = sbd_pkg::TGT_WINDOW;
            d_waddr = 23'({bank_reg, in_addr[14:1]});
            d_req   = 1'b1;
            if (in_addr[0])
            begin
                d_lstb = 1'b1;
                if (in_wr)
                begin
                    d_wword = {8'h00, in_data};
                end
            end
            else
            begin
                d_ustb = 1'b1;
                if (in_wr)
                begin
                    d_wword = {in_data, 8'h00};
                end
            end
        end
    end

    // RAM access issued on the input transfer; a write lands before any
    // later read, so back-to-back accesses need no forwarding.
    always_comb
    begin
        ram_req.en    = s_xfer && (d_tgt == sbd_pkg::TGT_RAM);
        ram_req.we    = in_wr;
        ram_req.idx   = sbd_pkg::ram_index(in_addr[12:0]);
        ram_req.wdata = in_data;
    end

    sbd_lram u_lram (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ram_req),
        .rdata (ram_rdata),
        .busy  (ram_busy)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= '0;
            v1_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (s_xfer)
            begin
                bank_reg <= bank_next;
            end
            if (s_xfer)
            begin
                v1_reg <= 1'b1;
            end
            else if (adv)
            begin
                v1_reg <= 1'b0;
            end
            if (adv)
            begin
                ov_reg <= v1_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            tgt1_reg    <= d_tgt;
            wr1_reg     <= in_wr;
            port1_reg   <= d_port;
            isdata1_reg <= d_isdata;
            waddr1_reg  <= d_waddr;
            ustb1_reg   <= d_ustb;
            lstb1_reg   <= d_lstb;
            wword1_reg  <= d_wword;
            req1_reg    <= d_req;
        end
        if (adv && v1_reg)
        begin
            otgt_reg    <= tgt1_reg;
            ord_reg     <= (tgt1_reg == sbd_pkg::TGT_RAM && !wr1_reg) ? ram_rdata : 8'h00;
            oport_reg   <= port1_reg;
            oisdata_reg <= isdata1_reg;
            owaddr_reg  <= waddr1_reg;
            oustb_reg   <= ustb1_reg;
            olstb_reg   <= lstb1_reg;
            owword_reg  <= wword1_reg;
            oreq_reg    <= req1_reg;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = otgt_reg;
    assign m_tdata  = {4'h0, oreq_reg, owword_reg, olstb_reg, oustb_reg,
                       owaddr_reg, oisdata_reg, oport_reg, ord_reg};

`ifndef SYNTHESIS
    a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ram_busy |-> !s_tready)
        else $error("input accepted during RAM clear");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !adv) |=> (v1_reg && $stable(tgt1_reg)))
        else $error("decode stage lost an item under stall");

    a_rd_only_ram: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != sbd_pkg::TGT_RAM) |-> (m_tdata[7:0] == 8'h00))
        else $error("read data on non-RAM target");

    a_req_targets: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[51]) |->
            (m_tuser == sbd_pkg::TGT_WINDOW || m_tuser == sbd_pkg::TGT_TONE))
        else $error("main request from wrong target");

    a_one_lane: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[33] && m_tdata[34]))
        else $error("both byte strobes set");
`endif

endmodule

// ===== rtl/sbd_lram.sv =====
// Local RAM with registered read and a clearing sweep after reset.
`timescale 1ns / 1ps

module sbd_lram (
    input  logic              clk,
    input  logic              rst_n,
    input  sbd_pkg::lram_req_t req,
    output logic [7:0]        rdata,
    output logic              busy
);

    logic [7:0]                 mem [sbd_pkg::RAM_DEPTH];
    logic [7:0]                 rdata_reg;
    logic                       clr_reg;
    logic [sbd_pkg::RAM_AW-1:0] clr_addr_reg;

    // sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == sbd_pkg::RAM_AW'(sbd_pkg::RAM_DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // array: sweep owns the write port while clearing
    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (req.en && req.we)
        begin
            mem[req.idx] <= req.wdata;
        end
        if (req.en && !req.we)
        begin
            rdata_reg <= mem[req.idx];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_reg;

endmodule

// ===== verif/sbd_access_checker.sv =====
// Checker for the sound CPU bus decoder: predicts each decode and compares transfers.
`timescale 1ns / 1ps

module sbd_access_checker
    import sbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic        s_tuser,   // [0] mode (1 = write)
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // [7:0] read_data, [8] sound_port, [9] sound_is_data,
                                   // [32:10] main_word_address, [33] upper_strobe,
                                   // [34] lower_strobe, [50:35] main_write_word,
                                   // [51] main_request, [55:52] zero
    input  logic [2:0]  m_tuser,   // [2:0] target
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  read_data;
        target_t     target;
        logic        sound_port;
        logic        sound_is_data;
        logic [22:0] main_word_address;
        logic        upper_strobe;
        logic        lower_strobe;
        logic [15:0] main_write_word;
        logic        main_request;
    } decode_result_t;

    localparam int REPORT_LIMIT = 10;

    // Shadow state; the block clears its RAM at reset, so zeros are the start point
    logic [7:0]           ram_shadow [RAM_DEPTH] = '{default: 8'h00};
    logic [BANK_BITS-1:0] bank_shadow = '0;
    decode_result_t       expected_decodes [$];

    // Decode one access and update the shadow RAM and bank register
    function automatic decode_result_t predict_decode(input logic wr, input logic [15:0] addr,
                                                      input logic [7:0] data);
        decode_result_t r;
        int idx;
        r = '0;
        r.target = TGT_UNMAPPED;
        if (addr < RAM_END)
        begin
            idx = int'(addr) % RAM_DEPTH;
            r.target = TGT_RAM;
            if (wr)
                ram_shadow[idx] = data;
            else
                r.read_data = ram_shadow[idx];
        end
        else if (addr >= SOUND_FIRST && addr <= SOUND_LAST)
        begin
            r.target        = TGT_SOUND;
            r.sound_port    = addr[1];
            r.sound_is_data = addr[0];
        end
        else if (addr == BANK_ADDR_0 || addr == BANK_ADDR_1)
        begin
            r.target = TGT_BANK;
            // serial load: new bit enters at the top
            if (wr)
                bank_shadow = (bank_shadow >> 1) | (BANK_BITS'(data[0]) << (BANK_BITS - 1));
        end
        else if (addr == TONE_ADDR)
        begin
            r.target = TGT_TONE;
            if (wr)
            begin
                r.main_word_address = TONE_WORD_ADDR;
                r.lower_strobe      = 1'b1;
                r.main_write_word   = {8'h00, data};
                r.main_request      = 1'b1;
            end
        end
        else if (addr >= WINDOW_FIRST)
        begin
            r.target            = TGT_WINDOW;
            r.main_word_address = 23'((32'(bank_shadow) << 14) + 32'(addr[14:1]));
            r.main_request      = 1'b1;
            if (addr[0])
            begin
                r.lower_strobe = 1'b1;
                if (wr)
                    r.main_write_word = {8'h00, data};
            end
            else
            begin
                r.upper_strobe = 1'b1;
                if (wr)
                    r.main_write_word = {data, 8'h00};
            end
        end
        return r;
    endfunction

    function automatic string show_decode(input decode_result_t r);
        return $sformatf("rd=%h tgt=%0d port=%b dat=%b wa=%h us=%b ls=%b ww=%h rq=%b",
                         r.read_data, r.target, r.sound_port, r.sound_is_data,
                         r.main_word_address, r.upper_strobe, r.lower_strobe,
                         r.main_write_word, r.main_request);
    endfunction

    always @(posedge clk)
    begin
        decode_result_t want;
        decode_result_t got;
        if (rst_n)
        begin
            // output side first: it always belongs to an older access
            if (m_tvalid && m_tready)
            begin
                got.read_data         = m_tdata[7:0];
                got.target            = target_t'(m_tuser);
                got.sound_port        = m_tdata[8];
                got.sound_is_data     = m_tdata[9];
                got.main_word_address = m_tdata[32:10];
                got.upper_strobe      = m_tdata[33];
                got.lower_strobe      = m_tdata[34];
                got.main_write_word   = m_tdata[50:35];
                got.main_request      = m_tdata[51];
                if (expected_decodes.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("unexpected result transfer: %s", show_decode(got));
                    errors = errors + 1;
                end
                else
                begin
                    want = expected_decodes.pop_front();
                    if (got.read_data         !== want.read_data         ||
                        got.target            !== want.target            ||
                        got.sound_port        !== want.sound_port        ||
                        got.sound_is_data     !== want.sound_is_data     ||
                        got.main_word_address !== want.main_word_address ||
                        got.upper_strobe      !== want.upper_strobe      ||
                        got.lower_strobe      !== want.lower_strobe      ||
                        got.main_write_word   !== want.main_write_word   ||
                        got.main_request      !== want.main_request)
                    begin
                        if (errors < REPORT_LIMIT)
                        begin
                            $display("mismatch expected: %s", show_decode(want));
                            $display("         actual:   %s", show_decode(got));
                        end
                        errors = errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_decodes.push_back(predict_decode(s_tuser, s_tdata[15:0],
                                                          s_tdata[23:16]));
            pending = expected_decodes.size();
        end
    end

endmodule

// ===== verif/tb_sound_cpu_bus_decoder_banked.sv =====
// Testbench top: drives CPU bus accesses into the decoder and reports the verdict.
`timescale 1ns / 1ps

module tb_sound_cpu_bus_decoder_banked;
    import sbd_pkg::*;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    localparam int ITEMS_PER_PHASE = 400;  // three random phases
    localparam int HOLD_CYCLES     = 300;  // long receiver hold-off, forces backpressure
    localparam int DRAIN_CYCLES    = 16;   // margin for stray results
    // RAM sweep after reset plus ~1250 accesses at worst-case idling, many times over
    localparam int CYCLE_LIMIT     = 200000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;    // [15:0] address, [23:16] write_data
    logic        s_tuser  = 1'b0;  // [0] mode (1 = write)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;          // [7:0] read_data, [8] sound_port, [9] sound_is_data,
                                   // [32:10] main_word_address, [33] upper_strobe,
                                   // [34] lower_strobe, [50:35] main_write_word,
                                   // [51] main_request, [55:52] zero
    logic [2:0]  m_tuser;          // [2:0] target

    int errors;
    int pending;
    int cycle_count = 0;

    // Idle rates in percent; the stimulus process moves them between phases
    int tx_idle_pct = 11;
    int rx_idle_pct = 45;
    bit hold_wanted = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sound_cpu_bus_decoder_banked dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sbd_access_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    // Watchdog: the run must end well before this
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_sound_cpu_bus_decoder_banked: errors");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    // The hold-off is counted here so the sender keeps offering meanwhile.
    initial
    begin
        bit held;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // One access transfer; gaps rolled per cycle at the current sender rate.
    // Called right after a rising edge, so each assignment lands on that edge.
    task automatic send_access(input logic wr, input logic [15:0] addr, input logic [7:0] data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= wr;
        s_tdata  <= {data, addr};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] pick_unmapped();
        case ($urandom_range(3))
            0: return 16'h2000 + 16'($urandom_range(16'h1FFF));
            1: return 16'h4004 + 16'($urandom_range(16'h5FFF - 16'h4004));
            2: return 16'h6002 + 16'($urandom_range(16'h7F10 - 16'h6002));
            default: return 16'h7F12 + 16'($urandom_range(16'h7FFF - 16'h7F12));
        endcase
    endfunction

    // One random access, or a well-formed bank load followed by window traffic.
    // Returns the number of accesses sent.
    task automatic send_random(output int sent);
        int sel;
        logic wr;
        logic [15:0] addr;
        sel  = $urandom_range(99);
        wr   = $urandom_range(1) ? MODE_WRITE : MODE_READ;
        sent = 1;
        if (sel < 5)
        begin
            // full nine-bit bank load then a few window accesses through it
            for (int i = 0; i < BANK_BITS; i++)
                send_access(MODE_WRITE, $urandom_range(1) ? BANK_ADDR_1 : BANK_ADDR_0,
                            8'($urandom_range(255)));
            for (int i = 0; i < 4; i++)
                send_access($urandom_range(1) ? MODE_WRITE : MODE_READ,
                            WINDOW_FIRST + 16'($urandom_range(16'h7FFF)),
                            8'($urandom_range(255)));
            sent = BANK_BITS + 4;
        end
        else
        begin
            if (sel < 38)
                // RAM: half into a small pool so reads hit earlier writes
                addr = $urandom_range(1) ? 16'($urandom_range(63))
                                         : 16'($urandom_range(RAM_END - 1));
            else if (sel < 62)
                addr = WINDOW_FIRST + 16'($urandom_range(16'h7FFF));
            else if (sel < 72)
            begin
                addr = $urandom_range(1) ? BANK_ADDR_1 : BANK_ADDR_0;
                wr   = ($urandom_range(99) < 80) ? MODE_WRITE : MODE_READ;
            end
            else if (sel < 80)
                addr = SOUND_FIRST + 16'($urandom_range(3));
            else if (sel < 85)
                addr = TONE_ADDR;
            else if (sel < 94)
                addr = pick_unmapped();
            else
                addr = 16'($urandom_range(16'hFFFF));
            send_access(wr, addr, 8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        int sent;
        int phase_count;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range edges, each target, read and write of each
        send_access(MODE_WRITE, 16'h0000, 8'hFF);
        send_access(MODE_READ,  16'h0000, 8'h00);
        send_access(MODE_WRITE, 16'h1FFF, 8'hA5);
        send_access(MODE_READ,  16'h1FFF, 8'h00);
        send_access(MODE_READ,  16'h0001, 8'hFF);   // never written: reads reset zero
        send_access(MODE_WRITE, 16'h2000, 8'h5A);   // just past RAM: unmapped
        send_access(MODE_READ,  16'h3FFF, 8'h00);
        send_access(MODE_READ,  16'h4000, 8'h00);   // sound chip reads: read data stays zero
        send_access(MODE_WRITE, 16'h4001, 8'h11);
        send_access(MODE_WRITE, 16'h4002, 8'h22);
        send_access(MODE_READ,  16'h4003, 8'h33);
        send_access(MODE_WRITE, 16'h4004, 8'h44);
        send_access(MODE_WRITE, BANK_ADDR_0, 8'h01); // top bit in
        send_access(MODE_WRITE, BANK_ADDR_1, 8'hFE); // data bit 0 only matters
        send_access(MODE_READ,  BANK_ADDR_0, 8'hFF); // bank read: no shift
        send_access(MODE_WRITE, 16'h6002, 8'h01);
        send_access(MODE_WRITE, 16'h7F10, 8'h77);
        send_access(MODE_WRITE, TONE_ADDR, 8'h9C);
        send_access(MODE_READ,  TONE_ADDR, 8'h00);   // tone read: no main request
        send_access(MODE_WRITE, 16'h7F12, 8'h00);
        send_access(MODE_READ,  16'h7FFF, 8'h00);
        send_access(MODE_WRITE, 16'h8000, 8'hC3);    // even: upper lane
        send_access(MODE_WRITE, 16'hFFFF, 8'h3C);    // odd: lower lane
        send_access(MODE_READ,  16'hFFFE, 8'hFF);    // window read: no write word
        send_access(MODE_READ,  16'h8001, 8'h00);

        // Random phase one: sender mostly busy, receiver stalls often
        phase_count = 0;
        while (phase_count < ITEMS_PER_PHASE)
        begin
            send_random(sent);
            phase_count += sent;
        end

        // Phase two: swapped rates; start with the long hold-off so both stages fill
        tx_idle_pct = 45;
        rx_idle_pct = 11;
        hold_wanted = 1'b1;
        phase_count = 0;
        while (phase_count < ITEMS_PER_PHASE)
        begin
            send_random(sent);
            phase_count += sent;
        end

        // Phase three: back-to-back on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        phase_count = 0;
        while (phase_count < ITEMS_PER_PHASE)
        begin
            send_random(sent);
            phase_count += sent;
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("tb_sound_cpu_bus_decoder_banked: clean");
        else
            $display("tb_sound_cpu_bus_decoder_banked: errors");
        $finish;
    end

endmodule
